// ===== rtl/charge_jump_split_finder_macros.svh =====
// Assertion macros shared by the charge jump split finder RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef CHARGE_JUMP_SPLIT_FINDER_MACROS_SVH
`define CHARGE_JUMP_SPLIT_FINDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CJSF_ASSERT_IMP(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CJSF_ASSERT_NXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/cjsf_pkg.sv =====
// Shared types and constants of the charge jump split finder.
// Used by the datapath, the controller and the top level; no dependencies.
`default_nettype none

package cjsf_pkg;

    localparam int CHARGE_W   = 20;
    localparam int MSH_W      = 9;
    localparam int TOL_W      = 8;
    localparam int THR_W      = 20;
    localparam int IDX_W      = 10;
    localparam int LIM_W      = TOL_W + THR_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_SIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOL      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR      = 2'd2;

    localparam logic [MSH_W-1:0] MSH_RESET = 9'd3;
    localparam logic [TOL_W-1:0] TOL_RESET = 8'd128;
    localparam logic [THR_W-1:0] THR_RESET = 20'd200;

    typedef struct packed {
        logic [CHARGE_W-1:0] charge;
        logic                last;
    } in_item_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] split_index;
    } out_item_t;

    typedef enum logic [2:0] {
        RD_ZERO,
        RD_ONE,
        RD_TWO,
        RD_JM1,
        RD_JP1,
        RD_IP2
    } rd_sel_t;

    typedef struct packed {
        logic    store;
        logic    init;
        logic    shift;
        rd_sel_t rd_sel;
        logic    judge_take;
        logic    step_left;
        logic    left_end;
        logic    step_right;
        logic    right_end;
        logic    next_i;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic short_clu;
        logic reject;
        logic wl_stop;
        logic wr_stop;
        logic too_big;
        logic scan_end;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/cjsf_dp.sv =====
// Datapath of the charge jump split finder: configuration registers, charge
// memory, scan window, plateau walker and output register.
// Depends on cjsf_pkg and the assertion macro header.
`default_nettype none
`include "charge_jump_split_finder_macros.svh"

module cjsf_dp #(
    parameter int MAX_HITS = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [cjsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cjsf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [cjsf_pkg::CHARGE_W-1:0]   charge,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output cjsf_pkg::out_item_t                  out_data,
    input  wire cjsf_pkg::dp_cmd_t               cmd,
    output cjsf_pkg::dp_stat_t                   stat
);
    import cjsf_pkg::*;

    localparam int AW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int CW = $clog2(MAX_HITS + 1);
    localparam int SW = (CW > MSH_W + 1) ? CW : MSH_W + 1;

    function automatic logic [CHARGE_W-1:0] absdiff(input logic [CHARGE_W-1:0] a,
                                                    input logic [CHARGE_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    logic [MSH_W-1:0]    msh_reg;
    logic [TOL_W-1:0]    tol_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [LIM_W-1:0]    lim_reg;
    logic [CW-1:0]       hit_cnt_reg;
    logic [CHARGE_W-1:0] mem [MAX_HITS];
    logic [CHARGE_W-1:0] rd_q_reg;
    logic [AW-1:0]       rd_addr;
    logic                mem_we;
    logic [CHARGE_W-1:0] qa_reg;
    logic [CHARGE_W-1:0] qb_reg;
    logic [CHARGE_W-1:0] qc_reg;
    logic [CHARGE_W-1:0] dl_reg;
    logic [CHARGE_W-1:0] dr_reg;
    logic [AW-1:0]       i_reg;
    logic [AW-1:0]       j_reg;
    logic [CHARGE_W-1:0] prev_reg;
    logic [MSH_W-1:0]    cnt_reg;
    logic                cl_ok_reg;
    logic [CHARGE_W-1:0] best_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    bidx_reg;
    logic                out_valid_reg;
    out_item_t           out_reg;
    out_item_t           out_next;
    logic [CHARGE_W-1:0] jump_max;
    logic [CHARGE_W-1:0] step_diff;
    logic                skip;
    logic                side_ok;
    logic                ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msh_reg <= MSH_RESET;
            tol_reg <= TOL_RESET;
            thr_reg <= THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MIN_SIDE: msh_reg <= cfg_wdata[MSH_W-1:0];
                REG_TOL:      tol_reg <= cfg_wdata[TOL_W-1:0];
                REG_THR:      thr_reg <= cfg_wdata[THR_W-1:0];
                default:      ;
            endcase
        end
    end

    assign mem_we = cmd.store && (hit_cnt_reg < CW'(MAX_HITS));

    always_comb
    begin
        case (cmd.rd_sel)
            RD_ZERO: rd_addr = '0;
            RD_ONE:  rd_addr = AW'(1);
            RD_TWO:  rd_addr = AW'(2);
            RD_JM1:  rd_addr = j_reg - AW'(1);
            RD_JP1:  rd_addr = j_reg + AW'(1);
            RD_IP2:  rd_addr = i_reg + AW'(2);
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[hit_cnt_reg[AW-1:0]] <= charge;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_q_reg <= mem[rd_addr];
    end

    assign skip = ((dl_reg < thr_reg) && (dr_reg < thr_reg)) ||
                  ((dl_reg > thr_reg) && (dr_reg > thr_reg));
    assign jump_max  = (dl_reg > dr_reg) ? dl_reg : dr_reg;
    assign step_diff = absdiff(prev_reg, rd_q_reg);
    assign side_ok   = cnt_reg >= msh_reg;
    assign ok        = found_reg && (best_reg > thr_reg);

    assign stat.short_clu = (SW'(hit_cnt_reg) < SW'({msh_reg, 1'b1})) ||
                            (hit_cnt_reg < CW'(3));
    assign stat.reject    = skip || (jump_max <= best_reg);
    assign stat.wl_stop   = (j_reg == '0) || side_ok;
    assign stat.wr_stop   = ((CW'(j_reg) + CW'(1)) >= hit_cnt_reg) || side_ok;
    assign stat.too_big   = {step_diff, {TOL_W{1'b0}}} > lim_reg;
    assign stat.scan_end  = (CW'(i_reg) + CW'(2)) >= hit_cnt_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        dl_reg <= absdiff(qb_reg, qa_reg);
        dr_reg <= absdiff(qb_reg, qc_reg);
        if (cmd.init)
        begin
            lim_reg <= LIM_W'(tol_reg) * LIM_W'(thr_reg);
        end
        if (cmd.shift)
        begin
            qa_reg <= qb_reg;
            qb_reg <= qc_reg;
            qc_reg <= rd_q_reg;
        end
        if (cmd.judge_take)
        begin
            prev_reg <= qa_reg;
        end
        else if (cmd.left_end)
        begin
            prev_reg <= qc_reg;
        end
        else if (cmd.step_left || cmd.step_right)
        begin
            prev_reg <= rd_q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            cnt_reg     <= '0;
            cl_ok_reg   <= 1'b0;
            best_reg    <= '0;
            found_reg   <= 1'b0;
            bidx_reg    <= '0;
        end
        else
        begin
            if (cmd.load_out)
            begin
                hit_cnt_reg <= '0;
            end
            else if (mem_we)
            begin
                hit_cnt_reg <= hit_cnt_reg + CW'(1);
            end

            if (cmd.init)
            begin
                i_reg <= AW'(1);
            end
            else if (cmd.next_i)
            begin
                i_reg <= i_reg + AW'(1);
            end

            if (cmd.judge_take)
            begin
                j_reg   <= i_reg - AW'(1);
                cnt_reg <= MSH_W'(1);
            end
            else if (cmd.left_end)
            begin
                j_reg   <= i_reg + AW'(1);
                cnt_reg <= MSH_W'(1);
            end
            else if (cmd.step_left)
            begin
                j_reg   <= j_reg - AW'(1);
                cnt_reg <= cnt_reg + MSH_W'(1);
            end
            else if (cmd.step_right)
            begin
                j_reg   <= j_reg + AW'(1);
                cnt_reg <= cnt_reg + MSH_W'(1);
            end

            if (cmd.left_end)
            begin
                cl_ok_reg <= side_ok;
            end

            if (cmd.init)
            begin
                best_reg  <= '0;
                found_reg <= 1'b0;
                bidx_reg  <= '0;
            end
            else
            begin
                if (cmd.judge_take)
                begin
                    best_reg <= jump_max;
                end
                if (cmd.right_end && cl_ok_reg && side_ok)
                begin
                    found_reg <= 1'b1;
                    bidx_reg  <= IDX_W'(i_reg);
                end
            end
        end
    end

    always_comb
    begin
        out_next.found       = ok;
        out_next.split_index = ok ? bidx_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `CJSF_ASSERT_NXT(a_out_loaded, cmd.load_out, out_valid_reg, "result not presented after load")
    `CJSF_ASSERT_IMP(a_count_bound, 1'b1, hit_cnt_reg <= CW'(MAX_HITS), "hit count overflow")
    `CJSF_ASSERT_NXT(a_split_taken, cmd.right_end && cl_ok_reg && side_ok && !cmd.init, found_reg, "accepted split not recorded")

endmodule

`default_nettype wire

// ===== rtl/cjsf_ctrl.sv =====
// Controller of the charge jump split finder: sequences loading, the scan over
// interior hits and the plateau walks. Depends on cjsf_pkg and the macro header.
`default_nettype none
`include "charge_jump_split_finder_macros.svh"

module cjsf_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_last,
    output logic                    in_ready,
    input  wire cjsf_pkg::dp_stat_t stat,
    output cjsf_pkg::dp_cmd_t       cmd
);
    import cjsf_pkg::*;

    typedef enum logic [13:0] {
        ST_LOAD   = 14'b00000000000001,
        ST_INIT   = 14'b00000000000010,
        ST_FILL_A = 14'b00000000000100,
        ST_FILL_B = 14'b00000000001000,
        ST_FILL_C = 14'b00000000010000,
        ST_DIFF   = 14'b00000000100000,
        ST_JUDGE  = 14'b00000001000000,
        ST_WL_CHK = 14'b00000010000000,
        ST_WL_CMP = 14'b00000100000000,
        ST_WR_CHK = 14'b00001000000000,
        ST_WR_CMP = 14'b00010000000000,
        ST_NEXT   = 14'b00100000000000,
        ST_ADV    = 14'b01000000000000,
        ST_FIN    = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_ZERO;
        in_ready   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.store = 1'b1;
                    if (in_last)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.init = 1'b1;
                if (stat.short_clu)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.rd_sel = RD_ZERO;
                    state_next = ST_FILL_A;
                end
            end
            ST_FILL_A:
            begin
                cmd.shift  = 1'b1;
                cmd.rd_sel = RD_ONE;
                state_next = ST_FILL_B;
            end
            ST_FILL_B:
            begin
                cmd.shift  = 1'b1;
                cmd.rd_sel = RD_TWO;
                state_next = ST_FILL_C;
            end
            ST_FILL_C:
            begin
                cmd.shift  = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                state_next = ST_JUDGE;
            end
            ST_JUDGE:
            begin
                if (stat.reject)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    cmd.judge_take = 1'b1;
                    state_next     = ST_WL_CHK;
                end
            end
            ST_WL_CHK:
            begin
                if (stat.wl_stop)
                begin
                    cmd.left_end = 1'b1;
                    state_next   = ST_WR_CHK;
                end
                else
                begin
                    cmd.rd_sel = RD_JM1;
                    state_next = ST_WL_CMP;
                end
            end
            ST_WL_CMP:
            begin
                if (stat.too_big)
                begin
                    cmd.left_end = 1'b1;
                    state_next   = ST_WR_CHK;
                end
                else
                begin
                    cmd.step_left = 1'b1;
                    state_next    = ST_WL_CHK;
                end
            end
            ST_WR_CHK:
            begin
                if (stat.wr_stop)
                begin
                    cmd.right_end = 1'b1;
                    state_next    = ST_NEXT;
                end
                else
                begin
                    cmd.rd_sel = RD_JP1;
                    state_next = ST_WR_CMP;
                end
            end
            ST_WR_CMP:
            begin
                if (stat.too_big)
                begin
                    cmd.right_end = 1'b1;
                    state_next    = ST_NEXT;
                end
                else
                begin
                    cmd.step_right = 1'b1;
                    state_next     = ST_WR_CHK;
                end
            end
            ST_NEXT:
            begin
                if (stat.scan_end)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.rd_sel = RD_IP2;
                    cmd.next_i = 1'b1;
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                cmd.shift  = 1'b1;
                state_next = ST_DIFF;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    `CJSF_ASSERT_IMP(a_load_out_free, cmd.load_out, stat.out_free, "result loaded over a pending transfer")
    `CJSF_ASSERT_IMP(a_left_read, state_reg == ST_WL_CMP, $past(cmd.rd_sel) == RD_JM1, "left compare without matching read")
    `CJSF_ASSERT_IMP(a_adv_read, state_reg == ST_ADV, $past(cmd.next_i), "window advance without index step")

endmodule

`default_nettype wire

// ===== rtl/charge_jump_split_finder.sv =====
// The block takes the hits of one cluster, one charge per cycle, and after the
// hit marked last it scans the stored charges for the best split hit, then
// offers one result (found flag and hit index). Loading runs at one hit per
// cycle. Input stalls during the scan, which walks the charge memory through
// its single read port. The scan visits each interior hit in turn. Every hit
// whose jump passes the threshold test and beats the best so far starts a
// plateau walk on each side, of at most min_side_hits - 1 steps. A cluster too
// short for a split skips the scan. A finished result waits in an output
// register while the next cluster loads. If the previous result has not been
// transferred when a scan ends, input stays stalled until it is.
// Depends on cjsf_pkg, cjsf_dp and cjsf_ctrl.
`default_nettype none

module charge_jump_split_finder #(
    parameter int MAX_HITS = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [cjsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cjsf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire cjsf_pkg::in_item_t              in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output cjsf_pkg::out_item_t                  out_data
);
    import cjsf_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    cjsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_data.last),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cjsf_dp #(
        .MAX_HITS (MAX_HITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .charge    (in_data.charge),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for charge_jump_split_finder: clusters of hit charges go in,
// and a scoreboard predicts the found flag and split index of each closed cluster.
// Depends on cjsf_pkg and the charge_jump_split_finder RTL.
import cjsf_pkg::*;

class split_scoreboard;
    localparam int MAX_HITS = 1024;

    logic [MSH_W-1:0]    min_side = MSH_RESET;
    logic [TOL_W-1:0]    tol      = TOL_RESET;
    logic [THR_W-1:0]    thr      = THR_RESET;
    logic [CHARGE_W-1:0] cluster_charges[$];
    out_item_t           expected_splits[$];
    int                  errors = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_MIN_SIDE: min_side = val[MSH_W-1:0];
            REG_TOL:      tol      = val[TOL_W-1:0];
            REG_THR:      thr      = val[THR_W-1:0];
            default: ;
        endcase
    endfunction

    function logic [CHARGE_W-1:0] charge_gap(logic [CHARGE_W-1:0] a, logic [CHARGE_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function logic step_breaks(logic [CHARGE_W-1:0] a, logic [CHARGE_W-1:0] b,
                               logic [LIM_W-1:0] lim);
        return {charge_gap(a, b), 8'h00} > lim;
    endfunction

    function out_item_t find_split();
        int                  n;
        int                  cl;
        int                  cr;
        int                  j;
        logic [LIM_W-1:0]    lim;
        logic [CHARGE_W-1:0] best;
        logic [CHARGE_W-1:0] dl;
        logic [CHARGE_W-1:0] dr;
        logic [CHARGE_W-1:0] m;
        logic                accepted;
        logic [IDX_W-1:0]    idx;
        out_item_t           res;
        n = cluster_charges.size();
        lim = tol * thr;
        best = '0;
        accepted = 1'b0;
        idx = '0;
        if (n >= 2 * int'(min_side) + 1) begin
            for (int i = 1; i + 1 < n; i++) begin
                dl = charge_gap(cluster_charges[i], cluster_charges[i-1]);
                dr = charge_gap(cluster_charges[i], cluster_charges[i+1]);
                if ((dl < thr && dr < thr) || (dl > thr && dr > thr))
                    continue;
                m = (dl > dr) ? dl : dr;
                if (m <= best)
                    continue;
                best = m;
                cl = 0;
                j = i - 1;
                forever
                begin
                    cl++;
                    if (j == 0)
                        break;
                    if (step_breaks(cluster_charges[j], cluster_charges[j-1], lim))
                        break;
                    j--;
                end
                cr = 0;
                j = i + 1;
                forever
                begin
                    cr++;
                    if (j + 1 >= n)
                        break;
                    if (step_breaks(cluster_charges[j], cluster_charges[j+1], lim))
                        break;
                    j++;
                end
                if (cl >= int'(min_side) && cr >= int'(min_side))
                begin
                    accepted = 1'b1;
                    idx = i[IDX_W-1:0];
                end
            end
        end
        res.found = accepted && (best > thr);
        res.split_index = res.found ? idx : '0;
        return res;
    endfunction

    function void note_hit(in_item_t item);
        if (cluster_charges.size() < MAX_HITS)
            cluster_charges.push_back(item.charge);
        if (item.last)
        begin
            expected_splits.push_back(find_split());
            cluster_charges.delete();
        end
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_result(out_item_t got);
        out_item_t want;
        if (expected_splits.size() == 0)
        begin
            report($sformatf("unexpected result found=%0d split_index=%0d",
                             got.found, got.split_index));
            return;
        end
        want = expected_splits.pop_front();
        if (got.found !== want.found)
            report($sformatf("found got %0d want %0d", got.found, want.found));
        if (got.split_index !== want.split_index)
            report($sformatf("split_index got %0d want %0d",
                             got.split_index, want.split_index));
    endtask
endclass

module tb;
    localparam int CHARGE_MAX  = (1 << CHARGE_W) - 1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 600;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_MIN_SIDE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;

    split_scoreboard sb = new();
    int              snd_idle_pct = 0;
    int              rcv_stall_pct = 0;
    logic            hold_req = 1'b0;
    int unsigned     cycles = 0;

    charge_jump_split_finder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // The long hold-off lets the result register fill and the input stall behind it.
    initial
    begin
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= rcv_stall_pct);
            @(posedge clk);
        end
    end

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
            IDLE_SENDER:   begin snd_idle_pct = 68; rcv_stall_pct = 0;  end
            IDLE_RECEIVER: begin snd_idle_pct = 0;  rcv_stall_pct = 68; end
            default:       begin snd_idle_pct = 22; rcv_stall_pct = 22; end
        endcase
    endtask

    task automatic send_hit(input logic [CHARGE_W-1:0] q, input logic lst);
        in_item_t item;
        item.charge = q;
        item.last = lst;
        while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_hit(item);
    endtask

    task automatic send_cluster(input logic [CHARGE_W-1:0] q[$]);
        foreach (q[i])
            send_hit(q[i], i == q.size() - 1);
    endtask

    task automatic write_settings(input int unsigned msh, input int unsigned tol,
                                  input int unsigned thr);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MIN_SIDE;
        cfg_wdata <= CFG_DATA_W'(msh);
        @(posedge clk);
        cfg_index <= REG_TOL;
        cfg_wdata <= CFG_DATA_W'(tol);
        @(posedge clk);
        cfg_index <= REG_THR;
        cfg_wdata <= CFG_DATA_W'(thr);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(REG_MIN_SIDE, CFG_DATA_W'(msh));
        sb.set_reg(REG_TOL, CFG_DATA_W'(tol));
        sb.set_reg(REG_THR, CFG_DATA_W'(thr));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_splits.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    function automatic int clamp_charge(input int v);
        if (v < 0)
            return 0;
        if (v > CHARGE_MAX)
            return CHARGE_MAX;
        return v;
    endfunction

    // Mostly plateaus joined by jumps near the threshold, with steps near the plateau
    // limit; the rest are random charges and short clusters.
    function automatic void build_cluster(ref logic [CHARGE_W-1:0] q[$]);
        int msh;
        int thr;
        int stp;
        int kind;
        int segs;
        int len;
        int lvl;
        int d;
        int r;
        msh = int'(sb.min_side);
        thr = int'(sb.thr);
        stp = (int'(sb.tol) * thr) >>> 8;
        q.delete();
        kind = $urandom_range(99);
        if (kind < 10 || msh > 12)
        begin
            len = $urandom_range(1, (msh > 12) ? 12 : 2 * msh);
            repeat (len) q.push_back(CHARGE_W'($urandom));
        end
        else if (kind < 25)
        begin
            len = $urandom_range(3, 24);
            repeat (len) q.push_back(CHARGE_W'($urandom));
        end
        else
        begin
            segs = $urandom_range(2, 3);
            lvl = $urandom_range(CHARGE_MAX);
            for (int s = 0; s < segs; s++)
            begin
                if (s != 0)
                begin
                    case ($urandom_range(4))
                        0: d = thr;
                        1: d = thr + 1;
                        2: d = (thr > 0) ? thr - 1 : 0;
                        3: d = $urandom_range(thr, (2 * thr + 1 > CHARGE_MAX) ?
                                              CHARGE_MAX : 2 * thr + 1);
                        default: d = $urandom_range(CHARGE_MAX);
                    endcase
                    if ($urandom_range(1) == 0 && lvl >= d)
                        lvl = lvl - d;
                    else if (lvl + d <= CHARGE_MAX)
                        lvl = lvl + d;
                    else if (lvl >= d)
                        lvl = lvl - d;
                    else
                        lvl = $urandom_range(CHARGE_MAX);
                end
                len = $urandom_range(1, msh + 2);
                repeat (len)
                begin
                    q.push_back(CHARGE_W'(lvl));
                    r = $urandom_range(99);
                    if (r < 10)
                        d = stp;
                    else if (r < 16)
                        d = stp + 1;
                    else
                        d = $urandom_range((stp > 64) ? 64 : stp);
                    lvl = clamp_charge($urandom_range(1) ? lvl + d : lvl - d);
                end
            end
        end
    endfunction

    task automatic run_random(input int budget);
        logic [CHARGE_W-1:0] clu[$];
        int sent;
        int k;
        sent = 0;
        k = 0;
        while (sent < budget)
        begin
            set_idle(idle_mode_t'((k / 3) % 4));
            build_cluster(clu);
            send_cluster(clu);
            sent += clu.size();
            k++;
        end
        set_idle(IDLE_NONE);
    endtask

    initial
    begin
        logic [CHARGE_W-1:0] clu[$];
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Split with a left plateau step exactly at the limit.
        clu = '{20'd100, 20'd200, 20'd200, 20'd200, 20'd700, 20'd700, 20'd700};
        send_cluster(clu);
        // Short clusters at the charge extremes.
        clu = '{20'hFFFFF};
        send_cluster(clu);
        clu = '{20'd0, 20'hFFFFF};
        send_cluster(clu);
        // Jump exactly at the threshold is a candidate but never beats it.
        clu = '{20'd0, 20'd0, 20'd0, 20'd0, 20'd200, 20'd200, 20'd200};
        send_cluster(clu);
        // A larger later jump that fails the plateau test keeps the earlier split.
        clu = '{20'd0, 20'd0, 20'd0, 20'd0, 20'd300, 20'd300, 20'd300, 20'd1300};
        send_cluster(clu);
        run_random(150);
        drain();

        write_settings(1, 0, 0);
        run_random(150);
        drain();

        write_settings(2, 255, CHARGE_MAX);
        run_random(120);
        drain();

        write_settings(5, 64, 5000);
        hold_req = 1'b1;
        run_random(150);
        drain();

        write_settings(511, 200, 1000);
        run_random(40);
        drain();

        write_settings(4, 255, 300);
        run_random(140);
        drain();

        write_settings(MSH_RESET, TOL_RESET, THR_RESET);
        run_random(40);
        drain();
        repeat (48) @(posedge clk);

        if (sb.expected_splits.size() != 0)
            sb.report("results still outstanding at the end of the run");
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
